// ===== hdl/fdet_pkg.sv =====
// Shared constants, codes and result layout of the spectrum frame signal detector.
package fdet_pkg;

  // Default sizes.
  localparam int MAX_BINS_DEF   = 1024;
  localparam int HIST_DEPTH_DEF = 24;

  // Field widths.
  localparam int PWR_W   = 12;
  localparam int TH_W    = 12;
  localparam int CF_W    = 23;
  localparam int SPAN_W  = 18;
  localparam int CFG_W   = 23;
  localparam int CIDX_W  = 2;
  localparam int PIDX_W  = 10;
  localparam int FREQ_W  = 24;
  localparam int BW_W    = 18;
  localparam int ACT_W   = 11;
  localparam int HOPS_W  = 5;
  localparam int CONF_W  = 10;
  localparam int CLS_W   = 3;
  localparam int IN_TDATA_W  = 16;
  localparam int OUT_TDATA_W = 96;

  // Register reset values.
  localparam logic signed [TH_W-1:0] THRESH_RST = -12'sd1088;
  localparam logic [CF_W-1:0]   CENTER_RST = 23'd2440000;
  localparam logic [SPAN_W-1:0] SPAN_RST   = 18'd100000;

  // Register indexes.
  localparam logic [CIDX_W-1:0] REG_THRESHOLD = 2'd0;
  localparam logic [CIDX_W-1:0] REG_CENTER    = 2'd1;
  localparam logic [CIDX_W-1:0] REG_SPAN      = 2'd2;

  // Input opcodes and queue record kinds.
  localparam logic OP_BIN    = 1'b0;
  localparam logic OP_CLEAR  = 1'b1;
  localparam logic REC_FRAME = 1'b0;
  localparam logic REC_CLEAR = 1'b1;

  // Detection and classification constants.
  localparam int HOP_DIST     = 18;
  localparam int HOP_MIN      = 4;
  localparam int MARGIN_FULL  = 384;
  localparam int BW_CTRL_MAX  = 8000;
  localparam int BW_VIDEO_MIN = 10000;
  localparam int BW_CTRL_MIN  = 400;
  localparam int ACT_VIDEO    = 35;
  localparam int CONF_CAP     = 980;
  localparam int CONF_SCALE   = 288;
  localparam int MARGIN_GAIN  = 250;
  localparam int BASE_HOP     = 860;
  localparam int BASE_VIDEO   = 820;
  localparam int BASE_CTRL    = 740;
  localparam int BASE_UNKNOWN = 450;
  // floor(q / 3) as (q * DIV3_MUL) >> 16, exact for q below 32768.
  localparam int DIV3_MUL     = 21846;

  // Signal class codes.
  localparam logic [CLS_W-1:0] CLS_NONE    = 3'd0;
  localparam logic [CLS_W-1:0] CLS_HOP     = 3'd1;
  localparam logic [CLS_W-1:0] CLS_VIDEO   = 3'd2;
  localparam logic [CLS_W-1:0] CLS_CTRL    = 3'd3;
  localparam logic [CLS_W-1:0] CLS_UNKNOWN = 3'd4;

  // Result item, packed with the first field in the highest bits.
  typedef struct packed {
    logic                     pad;
    logic                     frame_overflow;
    logic [HOPS_W-1:0]        hop_count;
    logic [ACT_W-1:0]         active_bins;
    logic [BW_W-1:0]          bandwidth_khz;
    logic signed [FREQ_W-1:0] peak_freq_khz;
    logic [PIDX_W-1:0]        peak_index;
    logic signed [PWR_W-1:0]  peak_power;
    logic [CONF_W-1:0]        confidence_permille;
    logic [CLS_W-1:0]         signal_class;
    logic                     detected;
  } result_t;

endpackage

// ===== hdl/fdet_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module fdet_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== hdl/fdet_fifo.sv =====
// Two-entry queue between the bin front end and the frame back end.
module fdet_fifo #(
  parameter int WIDTH = 8
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] din,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] dout,
  output logic             empty
);

  logic [WIDTH-1:0] ent_r [2];
  logic             wp_r;
  logic             rp_r;
  logic [1:0]       cnt_r;

  // Pointers and occupancy; payload entries carry no reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) begin
        ent_r[wp_r] <= din;
        wp_r        <= ~wp_r;
      end
      if (pop) begin
        rp_r <= ~rp_r;
      end
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, pop};
    end
  end

  assign full  = (cnt_r == 2'd2);
  assign empty = (cnt_r == 2'd0);
  assign dout  = ent_r[rp_r];

endmodule

// ===== hdl/fdet_div.sv =====
// Iterative restoring divider, one quotient bit per cycle.
module fdet_div #(
  parameter int DVD_W = 40,
  parameter int DVS_W = 14,
  localparam int STEP_W = $clog2(DVD_W + 1)
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [DVD_W-1:0] dividend,
  input  logic [DVS_W-1:0] divisor,
  output logic             done,
  output logic [DVD_W-1:0] quotient
);

  logic [DVD_W-1:0]  q_r;
  logic [DVS_W-1:0]  rem_r;
  logic [DVS_W-1:0]  dvs_r;
  logic [STEP_W-1:0] step_r;
  logic              busy_r;
  logic              done_r;
  logic [DVS_W:0]    rem_sh;
  logic              fits;
  logic [DVS_W:0]    rem_sub;

  // Shift in the next dividend bit and try the subtraction.
  always_comb begin
    rem_sh  = {rem_r, q_r[DVD_W-1]};
    fits    = (rem_sh >= {1'b0, dvs_r});
    rem_sub = rem_sh - {1'b0, dvs_r};
  end

  // Step sequencing; done pulses for one cycle after the last step.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      done_r <= busy_r && !start && (step_r == STEP_W'(1));
      if (start) begin
        q_r    <= dividend;
        rem_r  <= '0;
        dvs_r  <= divisor;
        step_r <= STEP_W'(DVD_W);
        busy_r <= 1'b1;
      end else if (busy_r) begin
        q_r    <= {q_r[DVD_W-2:0], fits};
        rem_r  <= fits ? rem_sub[DVS_W-1:0] : rem_sh[DVS_W-1:0];
        step_r <= step_r - 1'b1;
        if (step_r == STEP_W'(1)) begin
          busy_r <= 1'b0;
        end
      end
    end
  end

  assign done     = done_r;
  assign quotient = q_r;

endmodule

// ===== hdl/fdet_front.sv =====
// Front end: takes bins, keeps running frame statistics, queues frame and clear records.
module fdet_front #(
  parameter int MAX_BINS = fdet_pkg::MAX_BINS_DEF,
  localparam int IDX_W = $clog2(MAX_BINS),
  localparam int CNT_W = $clog2(MAX_BINS + 1),
  localparam int REC_W = 3 + 2 * CNT_W + fdet_pkg::PWR_W + 3 * IDX_W
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic signed [fdet_pkg::TH_W-1:0] threshold,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic                             in_opcode,
  input  logic signed [fdet_pkg::PWR_W-1:0] in_power,
  input  logic                             in_last,
  output logic                             rec_push,
  output logic [REC_W-1:0]                 rec_data,
  input  logic                             rec_full
);

  typedef struct packed {
    logic                              kind;
    logic [CNT_W-1:0]                  n;
    logic [CNT_W-1:0]                  act;
    logic signed [fdet_pkg::PWR_W-1:0] peak;
    logic [IDX_W-1:0]                  pidx;
    logic [IDX_W-1:0]                  first;
    logic [IDX_W-1:0]                  last;
    logic                              any;
    logic                              ovf;
  } rec_t;

  logic [CNT_W-1:0]                  bin_cnt_r, bin_cnt_nxt;
  logic [CNT_W-1:0]                  act_r, act_nxt;
  logic signed [fdet_pkg::PWR_W-1:0] peak_r, peak_nxt;
  logic [IDX_W-1:0]                  pidx_r, pidx_nxt;
  logic [IDX_W-1:0]                  first_r, first_nxt;
  logic [IDX_W-1:0]                  last_r, last_nxt;
  logic                              any_r, any_nxt;
  logic                              ovf_r, ovf_nxt;
  logic                              xfer;
  logic                              take_bin;
  logic                              close;
  logic [IDX_W-1:0]                  idx;
  rec_t                              rec;

  assign in_ready = ~rec_full;
  assign xfer     = in_valid & in_ready;
  assign take_bin = xfer & (in_opcode == fdet_pkg::OP_BIN);
  assign close    = take_bin & in_last;
  assign idx      = bin_cnt_r[IDX_W-1:0];

  // Statistics update for one accepted bin.
  always_comb begin
    bin_cnt_nxt = bin_cnt_r;
    act_nxt     = act_r;
    peak_nxt    = peak_r;
    pidx_nxt    = pidx_r;
    first_nxt   = first_r;
    last_nxt    = last_r;
    any_nxt     = any_r;
    ovf_nxt     = ovf_r;
    if (take_bin) begin
      if (bin_cnt_r < CNT_W'(MAX_BINS)) begin
        if ((bin_cnt_r == '0) || (in_power > peak_r)) begin
          peak_nxt = in_power;
          pidx_nxt = idx;
        end
        if (in_power >= threshold) begin
          act_nxt = act_r + 1'b1;
          if (!any_r) begin
            first_nxt = idx;
          end
          last_nxt = idx;
          any_nxt  = 1'b1;
        end
        bin_cnt_nxt = bin_cnt_r + 1'b1;
      end else begin
        // Bins beyond the frame limit are dropped and flagged.
        ovf_nxt = 1'b1;
      end
    end
  end

  // Record handed to the back end: a closed frame or a history clear.
  always_comb begin
    rec.kind  = (in_opcode == fdet_pkg::OP_CLEAR) ? fdet_pkg::REC_CLEAR : fdet_pkg::REC_FRAME;
    rec.n     = bin_cnt_nxt;
    rec.act   = act_nxt;
    rec.peak  = peak_nxt;
    rec.pidx  = pidx_nxt;
    rec.first = first_nxt;
    rec.last  = last_nxt;
    rec.any   = any_nxt;
    rec.ovf   = ovf_nxt;
  end

  assign rec_push = xfer & ((in_opcode == fdet_pkg::OP_CLEAR) | in_last);
  assign rec_data = rec;

  // Frame state registers, cleared when a frame closes.
  always_ff @(posedge clk) begin
    if (!rst_n || close) begin
      bin_cnt_r <= '0;
      act_r     <= '0;
      pidx_r    <= '0;
      first_r   <= '0;
      last_r    <= '0;
      any_r     <= 1'b0;
      ovf_r     <= 1'b0;
    end else begin
      bin_cnt_r <= bin_cnt_nxt;
      act_r     <= act_nxt;
      pidx_r    <= pidx_nxt;
      first_r   <= first_nxt;
      last_r    <= last_nxt;
      any_r     <= any_nxt;
      ovf_r     <= ovf_nxt;
    end
  end

  // Running peak value; the first bin of every frame overwrites it.
  always_ff @(posedge clk) begin
    peak_r <= peak_nxt;
  end

endmodule

// ===== hdl/fdet_back.sv =====
// Back end: peak history, hop walk, frequency and bandwidth division, class and result.
module fdet_back #(
  parameter int MAX_BINS      = fdet_pkg::MAX_BINS_DEF,
  parameter int HISTORY_DEPTH = fdet_pkg::HIST_DEPTH_DEF,
  localparam int IDX_W = $clog2(MAX_BINS),
  localparam int CNT_W = $clog2(MAX_BINS + 1),
  localparam int REC_W = 3 + 2 * CNT_W + fdet_pkg::PWR_W + 3 * IDX_W
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic signed [fdet_pkg::TH_W-1:0]   threshold,
  input  logic [fdet_pkg::CF_W-1:0]          center_freq_khz,
  input  logic [fdet_pkg::SPAN_W-1:0]        span_khz,
  input  logic                               rec_empty,
  input  logic [REC_W-1:0]                   rec_data,
  output logic                               rec_pop,
  output logic                               out_valid,
  input  logic                               out_ready,
  output fdet_pkg::result_t                  out_data
);

  localparam int HA_W   = $clog2(HISTORY_DEPTH);
  localparam int FILL_W = $clog2(HISTORY_DEPTH + 1);
  localparam int A_W    = fdet_pkg::CF_W + 3;
  localparam int NUM_W  = A_W + CNT_W + 2;
  localparam int DVS_W  = CNT_W + 1;
  localparam int LIM_W  = CNT_W + 14;
  localparam int WID_W  = fdet_pkg::SPAN_W + CNT_W;
  localparam int PS_W   = IDX_W + fdet_pkg::SPAN_W;
  localparam int X_W    = 19;
  localparam int Q0_W   = X_W - 7;
  localparam int QM_W   = Q0_W + 16;

  typedef struct packed {
    logic                              kind;
    logic [CNT_W-1:0]                  n;
    logic [CNT_W-1:0]                  act;
    logic signed [fdet_pkg::PWR_W-1:0] peak;
    logic [IDX_W-1:0]                  pidx;
    logic [IDX_W-1:0]                  first;
    logic [IDX_W-1:0]                  last;
    logic                              any;
    logic                              ovf;
  } rec_t;

  typedef enum logic [3:0] {
    S_IDLE, S_HINIT, S_HREF, S_HOPS, S_MUL, S_SUM,
    S_FDIV, S_FWAIT, S_BDIV, S_BWAIT, S_CLS, S_OUT
  } state_t;

  state_t                              state_r;
  rec_t                                rec_in;
  rec_t                                rec_r;
  logic [HA_W-1:0]                     head_r;
  logic [FILL_W-1:0]                   fill_r;
  logic [HA_W-1:0]                     ptr_r;
  logic [FILL_W-1:0]                   cnt_r;
  logic [IDX_W-1:0]                    ref_r;
  logic [FILL_W-1:0]                   hops_r;
  logic [CNT_W-1:0]                    den_r;
  logic signed [NUM_W-1:0]             prod_r;
  logic signed [NUM_W-1:0]             num_r;
  logic [WID_W-1:0]                    wid_r;
  logic [LIM_W-1:0]                    lim_lo_r;
  logic [LIM_W-1:0]                    lim_hi_r;
  logic [LIM_W-1:0]                    lim_vid_r;
  logic                                neg_r;
  logic [fdet_pkg::FREQ_W-1:0]         freq_r;
  logic [fdet_pkg::BW_W-1:0]           bw_r;
  logic                                det_r;
  logic [fdet_pkg::CLS_W-1:0]          cls_r;
  logic [X_W-1:0]                      x_r;
  logic                                out_valid_r;
  fdet_pkg::result_t                   res_r;

  logic                                ram_we;
  logic [HA_W-1:0]                     raddr;
  logic [IDX_W-1:0]                    rdata;
  logic [HA_W+1:0]                     start_sum;
  logic [HA_W-1:0]                     start_c;
  logic [HA_W-1:0]                     ptr_inc;
  logic [IDX_W-1:0]                    hop_gap;
  logic [CNT_W-1:0]                    den_c;
  logic signed [A_W-1:0]               a_c;
  logic signed [A_W+CNT_W:0]           prod_c;
  logic [CNT_W-1:0]                    lf_c;
  logic [WID_W-1:0]                    wid_c;
  logic [PS_W-1:0]                     ps_c;
  logic [NUM_W-1:0]                    mag_c;
  logic                                div_start;
  logic [NUM_W-1:0]                    dvd_c;
  logic [DVS_W-1:0]                    dvs_c;
  logic                                div_done;
  logic [NUM_W-1:0]                    div_q;
  logic signed [fdet_pkg::PWR_W:0]     m_c;
  logic [8:0]                          mcap_c;
  logic [9:0]                          base_c;
  logic [fdet_pkg::CLS_W-1:0]          cls_c;
  logic [QM_W-1:0]                     qm_c;
  logic [fdet_pkg::CONF_W:0]           q_c;
  logic [fdet_pkg::CONF_W-1:0]         conf_c;
  logic                                load_out;

  assign rec_in  = rec_data;
  assign rec_pop = (state_r == S_IDLE) && !rec_empty;
  assign ram_we  = rec_pop && (rec_in.kind == fdet_pkg::REC_FRAME);

  // Peak index history.
  fdet_ram #(
    .WIDTH (IDX_W),
    .DEPTH (HISTORY_DEPTH)
  ) u_hist (
    .clk   (clk),
    .we    (ram_we),
    .waddr (head_r),
    .wdata (rec_in.pidx),
    .raddr (raddr),
    .rdata (rdata)
  );

  // Oldest entry, wrap increment and read address of the history walk.
  always_comb begin
    start_sum = (HA_W+2)'(head_r) + (HA_W+2)'(HISTORY_DEPTH) - (HA_W+2)'(fill_r);
    if (start_sum >= (HA_W+2)'(HISTORY_DEPTH)) begin
      start_sum = start_sum - (HA_W+2)'(HISTORY_DEPTH);
    end
    start_c = start_sum[HA_W-1:0];
    ptr_inc = (ptr_r == HA_W'(HISTORY_DEPTH - 1)) ? '0 : ptr_r + 1'b1;
    case (state_r)
      S_HINIT: raddr = start_c;
      S_HOPS:  raddr = ptr_inc;
      default: raddr = ptr_r;
    endcase
    hop_gap = (rdata > ref_r) ? rdata - ref_r : ref_r - rdata;
  end

  // Frequency numerator and bandwidth products.
  always_comb begin
    den_c  = (rec_r.n > CNT_W'(1)) ? rec_r.n - 1'b1 : CNT_W'(1);
    a_c    = $signed({2'b00, center_freq_khz, 1'b0}) - $signed(A_W'(span_khz));
    prod_c = a_c * $signed({1'b0, den_c});
    lf_c   = CNT_W'(rec_r.last) - CNT_W'(rec_r.first) + 1'b1;
    wid_c  = lf_c * span_khz;
    ps_c   = rec_r.pidx * span_khz;
    mag_c  = num_r[NUM_W-1] ? NUM_W'(-num_r) : NUM_W'(num_r);
  end

  // One divider shared by the frequency and the bandwidth.
  assign div_start = (state_r == S_FDIV) || (state_r == S_BDIV);
  assign dvd_c     = (state_r == S_FDIV) ? mag_c : NUM_W'(wid_r);
  assign dvs_c     = (state_r == S_FDIV) ? {den_r, 1'b0} : {1'b0, rec_r.n};

  fdet_div #(
    .DVD_W (NUM_W),
    .DVS_W (DVS_W)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (dvd_c),
    .divisor  (dvs_c),
    .done     (div_done),
    .quotient (div_q)
  );

  // Class decision and margin.
  always_comb begin
    m_c    = (fdet_pkg::PWR_W+1)'(rec_r.peak) - (fdet_pkg::PWR_W+1)'(threshold);
    mcap_c = (m_c > (fdet_pkg::PWR_W+1)'(fdet_pkg::MARGIN_FULL)) ?
             9'(fdet_pkg::MARGIN_FULL) : m_c[8:0];
    if ((32'(hops_r) >= fdet_pkg::HOP_MIN) && (wid_r < WID_W'(lim_hi_r))) begin
      cls_c  = fdet_pkg::CLS_HOP;
      base_c = 10'(fdet_pkg::BASE_HOP);
    end else if ((wid_r >= WID_W'(lim_vid_r)) &&
                 (32'(rec_r.act) >= fdet_pkg::ACT_VIDEO)) begin
      cls_c  = fdet_pkg::CLS_VIDEO;
      base_c = 10'(fdet_pkg::BASE_VIDEO);
    end else if ((wid_r > WID_W'(lim_lo_r)) && (wid_r < WID_W'(lim_hi_r))) begin
      cls_c  = fdet_pkg::CLS_CTRL;
      base_c = 10'(fdet_pkg::BASE_CTRL);
    end else begin
      cls_c  = fdet_pkg::CLS_UNKNOWN;
      base_c = 10'(fdet_pkg::BASE_UNKNOWN);
    end
  end

  // Confidence: divide by 384 as a shift by 7 and a reciprocal multiply by 3.
  always_comb begin
    qm_c   = QM_W'(x_r[X_W-1:7]) * QM_W'(fdet_pkg::DIV3_MUL);
    q_c    = qm_c[16 +: fdet_pkg::CONF_W+1];
    conf_c = (q_c > (fdet_pkg::CONF_W+1)'(fdet_pkg::CONF_CAP)) ?
             fdet_pkg::CONF_W'(fdet_pkg::CONF_CAP) : q_c[fdet_pkg::CONF_W-1:0];
  end

  assign load_out = (state_r == S_OUT) && (!out_valid_r || out_ready);

  // Sequencer with its datapath and the result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      head_r      <= '0;
      fill_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && out_ready && !load_out) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (!rec_empty) begin
            if (rec_in.kind == fdet_pkg::REC_CLEAR) begin
              head_r <= '0;
              fill_r <= '0;
            end else begin
              rec_r  <= rec_in;
              head_r <= (head_r == HA_W'(HISTORY_DEPTH - 1)) ? '0 : head_r + 1'b1;
              if (fill_r < FILL_W'(HISTORY_DEPTH)) begin
                fill_r <= fill_r + 1'b1;
              end
              state_r <= S_HINIT;
            end
          end
        end
        S_HINIT: begin
          ptr_r   <= (start_c == HA_W'(HISTORY_DEPTH - 1)) ? '0 : start_c + 1'b1;
          cnt_r   <= FILL_W'(1);
          hops_r  <= '0;
          state_r <= S_HREF;
        end
        S_HREF: begin
          ref_r   <= rdata;
          state_r <= S_HOPS;
        end
        S_HOPS: begin
          // The reference moves only when a hop is counted.
          if (cnt_r < fill_r) begin
            if (32'(hop_gap) > fdet_pkg::HOP_DIST) begin
              hops_r <= hops_r + 1'b1;
              ref_r  <= rdata;
            end
            ptr_r <= ptr_inc;
            cnt_r <= cnt_r + 1'b1;
          end else begin
            state_r <= S_MUL;
          end
        end
        S_MUL: begin
          den_r   <= den_c;
          prod_r  <= NUM_W'(prod_c);
          wid_r   <= (rec_r.any && (rec_r.n > CNT_W'(1))) ? wid_c : '0;
          state_r <= S_SUM;
        end
        S_SUM: begin
          num_r     <= prod_r + $signed(NUM_W'({ps_c, 1'b0}));
          lim_lo_r  <= rec_r.n * LIM_W'(fdet_pkg::BW_CTRL_MIN);
          lim_hi_r  <= rec_r.n * LIM_W'(fdet_pkg::BW_CTRL_MAX);
          lim_vid_r <= rec_r.n * LIM_W'(fdet_pkg::BW_VIDEO_MIN);
          state_r   <= S_FDIV;
        end
        S_FDIV: begin
          neg_r   <= num_r[NUM_W-1];
          state_r <= S_FWAIT;
        end
        S_FWAIT: begin
          // Quotient of magnitudes, sign restored: truncation toward zero.
          if (div_done) begin
            freq_r  <= neg_r ? fdet_pkg::FREQ_W'(0) - div_q[fdet_pkg::FREQ_W-1:0] :
                               div_q[fdet_pkg::FREQ_W-1:0];
            state_r <= S_BDIV;
          end
        end
        S_BDIV: begin
          state_r <= S_BWAIT;
        end
        S_BWAIT: begin
          if (div_done) begin
            bw_r    <= div_q[fdet_pkg::BW_W-1:0];
            state_r <= S_CLS;
          end
        end
        S_CLS: begin
          det_r   <= (rec_r.peak >= threshold);
          cls_r   <= cls_c;
          x_r     <= X_W'(base_c) * X_W'(fdet_pkg::CONF_SCALE) +
                     X_W'(mcap_c) * X_W'(fdet_pkg::MARGIN_GAIN);
          state_r <= S_OUT;
        end
        S_OUT: begin
          if (load_out) begin
            res_r.pad                 <= 1'b0;
            res_r.frame_overflow      <= rec_r.ovf;
            res_r.hop_count           <= fdet_pkg::HOPS_W'(hops_r);
            res_r.active_bins         <= fdet_pkg::ACT_W'(rec_r.act);
            res_r.bandwidth_khz       <= bw_r;
            res_r.peak_freq_khz       <= freq_r;
            res_r.peak_index          <= fdet_pkg::PIDX_W'(rec_r.pidx);
            res_r.peak_power          <= rec_r.peak;
            res_r.confidence_permille <= det_r ? conf_c : '0;
            res_r.signal_class        <= det_r ? cls_r : fdet_pkg::CLS_NONE;
            res_r.detected            <= det_r;
            out_valid_r               <= 1'b1;
            state_r                   <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = res_r;

endmodule

// ===== hdl/spectrum_frame_signal_detector.sv =====
// Top level of the spectrum frame signal detector: ports, registers, front, queue and back.
//
// Channel | Direction | Transfer when        | Carries
// in_     | slave     | in_tvalid & ready    | tdata power, tuser opcode, tlast last_bin
// out_    | master    | out_tvalid & ready   | tdata one frame summary
// cfg_    | write     | cfg_valid & ready    | cfg_index register, cfg_data value
//
// Bins are taken one per cycle; the front end only stalls while the two-entry
// frame queue is full.
// Each frame summary is worked out in the back end by a history walk through the RAM
// read port, then two passes of the shared one-bit-per-cycle divider over a NUM_W-bit
// dividend, NUM_W being 28 plus the bin count width.
// Reset is synchronous and active low and clears all control state; the history
// needs no clearing pass. A stalled result stays in the output register while
// the back end goes on with the next frame.
module spectrum_frame_signal_detector #(
  parameter int MAX_BINS      = fdet_pkg::MAX_BINS_DEF,
  parameter int HISTORY_DEPTH = fdet_pkg::HIST_DEPTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  // [11:0] power, [15:12] zero
  input  logic [fdet_pkg::IN_TDATA_W-1:0]     in_tdata,
  // [0] opcode
  input  logic                                in_tuser,
  input  logic                                in_tlast,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // [0] detected, [3:1] signal_class, [13:4] confidence_permille, [25:14] peak_power,
  // [35:26] peak_index, [59:36] peak_freq_khz, [77:60] bandwidth_khz,
  // [88:78] active_bins, [93:89] hop_count, [94] frame_overflow, [95] zero
  output logic [fdet_pkg::OUT_TDATA_W-1:0]    out_tdata,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [fdet_pkg::CIDX_W-1:0]         cfg_index,
  input  logic [fdet_pkg::CFG_W-1:0]          cfg_data
);

  localparam int IDX_W = $clog2(MAX_BINS);
  localparam int CNT_W = $clog2(MAX_BINS + 1);
  localparam int REC_W = 3 + 2 * CNT_W + fdet_pkg::PWR_W + 3 * IDX_W;

  logic signed [fdet_pkg::TH_W-1:0] threshold_r;
  logic [fdet_pkg::CF_W-1:0]        center_r;
  logic [fdet_pkg::SPAN_W-1:0]      span_r;
  logic                             rec_push;
  logic [REC_W-1:0]                 rec_wdata;
  logic                             rec_full;
  logic                             rec_pop;
  logic [REC_W-1:0]                 rec_rdata;
  logic                             rec_empty;
  fdet_pkg::result_t                res;

  // Configuration registers.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      threshold_r <= fdet_pkg::THRESH_RST;
      center_r    <= fdet_pkg::CENTER_RST;
      span_r      <= fdet_pkg::SPAN_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        fdet_pkg::REG_THRESHOLD: threshold_r <= $signed(cfg_data[fdet_pkg::TH_W-1:0]);
        fdet_pkg::REG_CENTER:    center_r    <= cfg_data[fdet_pkg::CF_W-1:0];
        fdet_pkg::REG_SPAN:      span_r      <= cfg_data[fdet_pkg::SPAN_W-1:0];
        default: ;
      endcase
    end
  end

  fdet_front #(
    .MAX_BINS (MAX_BINS)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .threshold (threshold_r),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_opcode (in_tuser),
    .in_power  ($signed(in_tdata[fdet_pkg::PWR_W-1:0])),
    .in_last   (in_tlast),
    .rec_push  (rec_push),
    .rec_data  (rec_wdata),
    .rec_full  (rec_full)
  );

  fdet_fifo #(
    .WIDTH (REC_W)
  ) u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (rec_push),
    .din   (rec_wdata),
    .full  (rec_full),
    .pop   (rec_pop),
    .dout  (rec_rdata),
    .empty (rec_empty)
  );

  fdet_back #(
    .MAX_BINS      (MAX_BINS),
    .HISTORY_DEPTH (HISTORY_DEPTH)
  ) u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .threshold       (threshold_r),
    .center_freq_khz (center_r),
    .span_khz        (span_r),
    .rec_empty       (rec_empty),
    .rec_data        (rec_rdata),
    .rec_pop         (rec_pop),
    .out_valid       (out_tvalid),
    .out_ready       (out_tready),
    .out_data        (res)
  );

  assign out_tdata = res;

  // A frame below the threshold carries neither class nor confidence.
  a_undetected_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !res.detected) |->
      (res.signal_class == fdet_pkg::CLS_NONE) && (res.confidence_permille == '0))
    else $error("undetected frame has a class or confidence");

  // Confidence never exceeds its cap.
  a_conf_cap: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (32'(res.confidence_permille) <= fdet_pkg::CONF_CAP))
    else $error("confidence above cap");

  // The back end only pops records that are there.
  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    rec_pop |-> !rec_empty)
    else $error("frame queue popped while empty");

endmodule
